// ===== hw/rtl/lswq_pkg.sv =====
// ----------------------------------------------------------------------------
// lswq_pkg
// Shared constants and types for the light sensor window qualifier.
// ----------------------------------------------------------------------------
package lswq_pkg;

  localparam int unsigned SampleW         = 10;
  localparam int unsigned DefWindowDepth  = 8;
  localparam logic [SampleW-1:0] ThreshResetVal = 10'd512;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StWalk  = 5'b00010,
    StDrain = 5'b00100,
    StCheck = 5'b01000,
    StDiv   = 5'b10000
  } lswq_state_e;

endpackage

// ===== hw/rtl/light_sensor_window_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// light_sensor_window_qualifier_unit
// Window average of light samples with stuck-sensor and bright-light checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per transfer; m_axis returns exactly one result
//   per sample, in order. cfg_we_i/cfg_wdata_i write the threshold while idle.
//   Each sample is written to a window RAM, then the window is walked one
//   entry per cycle through a single compare/add datapath, and a valid window
//   is divided by its fill count in a one-bit-per-cycle divider.
// Sequencing:
//   After the input transfer the window is walked and drained, then checked;
//   a valid window goes on through the divider before its result is held.
//   One sample in flight at a time; the walk length, the divider width and
//   any output back-pressure set the rate.
// Reset:
//   Threshold returns to 512, window is empty, held average is zero.
// Stall:
//   The output register holds a finished result until taken; a later result
//   waits in the check or divide state and no new sample is accepted.
// ----------------------------------------------------------------------------
module light_sensor_window_qualifier_unit
  import lswq_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DefWindowDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SampleW-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [9:0] sample, [10] early_mode_seen
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] covered, [1] average_valid, [11:2] average
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AddrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW  = SampleW + $clog2(WINDOW_DEPTH);

  lswq_state_e        state_q, state_d;
  logic [SampleW-1:0] thr_q;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [AddrW-1:0]   newest_q, newest_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic               rd_vld_q;
  logic [SampleW-1:0] sample_q;
  logic               early_q;
  logic               covered_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               mismatch_q, mismatch_d;
  logic               bright_q, bright_d;
  logic               valid_q, valid_d;
  logic [SampleW-1:0] held_q, held_d;
  logic               m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q;
  // divider result captured; set between done pulse and the output load
  logic               div_seen_q;

  logic               s_fire, out_load, stuck, win_valid, div_start, div_done;
  logic [SampleW-1:0] in_sample, rd_data;
  logic [SumW-1:0]    quotient;

  assign in_sample     = s_axis_tdata[SampleW-1:0];
  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    newest_d = newest_q;
    fill_d   = fill_q;
    if (s_fire) begin
      if (fill_q != '0) begin
        newest_d = (newest_q == AddrW'(WINDOW_DEPTH - 1)) ? '0 : newest_q + 1'b1;
      end
      if (fill_q < FillW'(WINDOW_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  lswq_ram #(
    .Width (SampleW),
    .Depth (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (s_fire),
    .waddr_i (newest_d),
    .wdata_i (in_sample),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign stuck     = (fill_q >= FillW'(2)) && !mismatch_q;
  assign win_valid = !(stuck || (bright_q && early_q));
  assign div_start = (state_q == StCheck) && win_valid;

  lswq_div #(
    .DividendW (SumW),
    .DivisorW  (FillW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    mismatch_d = mismatch_q;
    bright_d   = bright_q;
    valid_d    = valid_q;
    held_d     = held_q;
    out_load   = 1'b0;
    if (rd_vld_q) begin
      sum_d = sum_q + SumW'(rd_data);
      if (rd_data != sample_q) mismatch_d = 1'b1;
      if (rd_data > thr_q)     bright_d   = 1'b1;
    end
    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          idx_d      = '0;
          sum_d      = '0;
          mismatch_d = 1'b0;
          bright_d   = 1'b0;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (FillW'(idx_q) == fill_q - 1'b1) begin
          state_d = StDrain;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDrain: begin
        state_d = StCheck;
      end
      StCheck: begin
        valid_d = win_valid;
        state_d = StDiv;
        if (!win_valid && (!m_valid_q || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      StDiv: begin
        if (valid_q && div_done) held_d = quotient[SampleW-1:0];
        if ((!valid_q || div_done || div_seen_q) && (!m_valid_q || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_seen_q <= 1'b0;
    end else if (out_load || s_fire) begin
      div_seen_q <= 1'b0;
    end else if (div_done) begin
      div_seen_q <= 1'b1;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      thr_q     <= ThreshResetVal;
      fill_q    <= '0;
      newest_q  <= '0;
      rd_vld_q  <= 1'b0;
      held_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      fill_q    <= fill_d;
      newest_q  <= newest_d;
      rd_vld_q  <= (state_q == StWalk);
      held_q    <= held_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    sum_q      <= sum_d;
    mismatch_q <= mismatch_d;
    bright_q   <= bright_d;
    valid_q    <= valid_d;
    if (s_fire) begin
      sample_q  <= in_sample;
      early_q   <= s_axis_tdata[SampleW];
      covered_q <= (in_sample <= thr_q);
    end
    if (out_load) begin
      m_data_q <= OutDataW'({held_d, valid_d, covered_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_accept_starts_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == StWalk))
    else $error("accepted sample did not start the window walk");

  a_newest_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> (FillW'(newest_q) < fill_q))
    else $error("newest slot outside the filled part of the window");

  a_held_from_divider : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != $past(held_q)) |-> $past(div_done))
    else $error("held average changed without a divider result");

  a_no_load_while_walking : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StWalk) || (state_q == StDrain)) |-> !out_load)
    else $error("result loaded before the window walk finished");
`endif

endmodule

// ===== hw/rtl/lswq_ram.sv =====
// ----------------------------------------------------------------------------
// lswq_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lswq_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lswq_div.sv =====
// ----------------------------------------------------------------------------
// lswq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lswq_div #(
  parameter int unsigned DividendW = 13,
  parameter int unsigned DivisorW  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] dvd_q, dvd_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DivisorW:0]    rem_shift;
  logic [DivisorW:0]    diff;
  logic                 qbit;

  assign rem_shift = {rem_q, dvd_q[DividendW-1]};
  assign diff      = rem_shift - {1'b0, dvs_q};
  assign qbit      = (rem_shift >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DividendW-2:0], qbit};
      rem_d = qbit ? diff[DivisorW-1:0] : rem_shift[DivisorW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DividendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== bench/light_sensor_window_qualifier_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_window_qualifier_unit_test
// Drives light samples through the unit under several threshold settings and
// handshake mixes, tracks the sample window and held average alongside, and
// compares every returned result field by field against that prediction.
// ----------------------------------------------------------------------------
module light_sensor_window_qualifier_unit_test;
  import lswq_pkg::*;

  localparam int unsigned WinDepth      = DefWindowDepth;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 40;

  typedef struct packed {
    logic [SampleW-1:0] average;
    logic               average_valid;
    logic               covered;
  } light_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SampleW-1:0]  cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  light_sensor_window_qualifier_unit #(
    .WINDOW_DEPTH(WinDepth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow of the unit's window and threshold
  logic [SampleW-1:0] win_mem [WinDepth];
  int unsigned        win_fill;
  int unsigned        win_head;
  logic [SampleW-1:0] held_mean;
  logic [SampleW-1:0] threshold_q;

  light_result_t expected_results[$];
  int unsigned   error_count;
  int unsigned   n_samples;
  int unsigned   n_results;
  int unsigned   n_valid;
  int unsigned   n_held;
  int unsigned   sender_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   hold_request;
  int unsigned   hold_left;
  int unsigned   quiet_cycles;
  logic [SampleW-1:0] last_sample;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic light_result_t qualify_sample(logic [SampleW-1:0] smp, logic early);
    light_result_t      res;
    int unsigned        total;
    int unsigned        k;
    logic               stuck;
    logic               bright;
    logic               ok;
    logic [SampleW-1:0] v;
    if (win_fill != 0) win_head = (win_head + 1) % WinDepth;
    win_mem[win_head] = smp;
    if (win_fill < WinDepth) win_fill++;
    stuck  = (win_fill >= 2);
    bright = 1'b0;
    total  = 0;
    for (k = 0; k < win_fill; k++) begin
      v = win_mem[(win_head + WinDepth - k) % WinDepth];
      if (v != smp) stuck = 1'b0;
      if (v > threshold_q) bright = 1'b1;
      total += v;
    end
    ok = !(stuck || (bright && early));
    if (ok) held_mean = SampleW'(total / win_fill);
    res.covered       = (smp <= threshold_q);
    res.average_valid = ok;
    res.average       = held_mean;
    return res;
  endfunction

  task automatic send_sample(logic [SampleW-1:0] smp, logic early);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-SampleW-1){1'b0}}, early, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(qualify_sample(smp, early));
    last_sample = smp;
    n_samples++;
  endtask

  task automatic write_threshold(logic [SampleW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    threshold_q = value;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(4))
      0, 1: v = $urandom_range(1023);
      2: begin
        v = int'(threshold_q) + int'($urandom_range(8)) - 4;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      3: v = ($urandom_range(1)) ? 1023 : 0;
      default: v = last_sample;
    endcase
    return SampleW'(v);
  endfunction

  // mostly runs of equal samples and mixed windows, with the early flag in a
  // minority so that both window checks pass and fail often
  task automatic send_random_samples(int unsigned count);
    int unsigned        sent;
    int unsigned        run;
    logic [SampleW-1:0] smp;
    logic               early;
    sent = 0;
    while (sent < count) begin
      smp   = pick_sample();
      early = ($urandom_range(99) < 30);
      run   = ($urandom_range(9) < 3) ? $urandom_range(2, 10) : 1;
      repeat (run) begin
        send_sample(smp, early);
        sent++;
        if ($urandom_range(3) == 0) early = ~early;
      end
    end
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_sample(10'd600, 1'b1);   // lone sample, bright in early mode: held zero
    send_sample(10'd600, 1'b0);   // two equal samples: stuck
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd512, 1'b0);
    send_sample(10'd513, 1'b0);
    send_sample(10'd513, 1'b1);
    repeat (8) send_sample(10'd300, 1'b0);
    send_sample(10'd300, 1'b1);
    write_threshold(10'd1023);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd1023, 1'b0);
    write_threshold(10'd0);
    send_sample(10'd0, 1'b1);
    send_sample(10'd1, 1'b0);
    send_sample(10'd0, 1'b0);
    write_threshold(10'd512);
    send_sample(10'd700, 1'b1);   // raised threshold still flags older samples
  endtask

  task automatic test_traffic_mix(int unsigned idle_pct, int unsigned stall_pct,
                                  logic [SampleW-1:0] thresh, int unsigned count);
    write_threshold(thresh);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    send_random_samples(count);
  endtask

  task automatic test_output_backpressure();
    write_threshold(SampleW'($urandom_range(1023)));
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 400;
    send_random_samples(20);
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    light_result_t exp_r;
    light_result_t got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = m_axis_tdata[$bits(light_result_t)-1:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual 0x%0h",
                 $time, got_r);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("covered", exp_r.covered, got_r.covered);
        check_field("average_valid", exp_r.average_valid, got_r.average_valid);
        check_field("average", exp_r.average, got_r.average);
        n_results++;
        if (exp_r.average_valid) n_valid++;
        else n_held++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    win_fill        = 0;
    win_head        = 0;
    held_mean       = '0;
    threshold_q     = ThreshResetVal;
    error_count     = 0;
    n_samples       = 0;
    n_results       = 0;
    n_valid         = 0;
    n_held          = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    last_sample     = '0;
    for (int i = 0; i < WinDepth; i++) win_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_traffic_mix(0, 0, SampleW'($urandom_range(1023)), 190);
    test_traffic_mix(76, 0, 10'd1023, 190);
    test_traffic_mix(0, 76, 10'd0, 190);
    test_traffic_mix(10, 10, SampleW'($urandom_range(1023)), 190);
    test_output_backpressure();

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d results (%0d fresh averages, %0d held).",
             n_samples, n_results, n_valid, n_held);
    $display("Covered threshold extremes, stuck runs, early-mode windows and long backpressure.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== light_sensor_window_qualifier_unit.f =====
hw/rtl/lswq_pkg.sv
hw/rtl/lswq_ram.sv
hw/rtl/lswq_div.sv
hw/rtl/light_sensor_window_qualifier_unit.sv
bench/light_sensor_window_qualifier_unit_test.sv
